@@ sv/ptw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, constants and helper functions of the page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

    // store depth must be a power of two (512 .. 1M words)
    localparam int STORE_DEPTH = 4096;
    localparam int AW          = $clog2(STORE_DEPTH);

    localparam int VA_W   = 48;
    localparam int PA_W   = 52;
    localparam int ENT_W  = 64;
    localparam int SIDX_W = 12;
    localparam int IDX_W  = 9;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_HUGE    = 7;

    localparam logic       STATUS_OK    = 1'b0;
    localparam logic       STATUS_FAULT = 1'b1;

    localparam logic [1:0] PS_4K = 2'd0;
    localparam logic [1:0] PS_2M = 2'd1;
    localparam logic [1:0] PS_1G = 2'd2;

    typedef logic [AW-1:0] word_addr_t;

    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_READ      = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_UNMAP     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_RDWAIT,
        S_WALK,
        S_CHECK,
        S_CLEAR,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        ADDR_SIDX,
        ADDR_ROOT,
        ADDR_NEXT,
        ADDR_LAST
    } addr_sel_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_FAULT,
        RES_READ,
        RES_GIB,
        RES_MIB,
        RES_LEAF,
        RES_UNMAP
    } res_sel_t;

    typedef struct packed {
        logic      load_in;
        logic      mem_rd;
        logic      mem_wr;
        addr_sel_t addr_sel;
        logic      wdata_zero;
        logic      level_clr;
        logic      level_inc;
        logic      res_load;
        res_sel_t  res_sel;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        op_t        op;
        logic       present;
        logic       huge;
        logic [1:0] level;
    } dp_status_t;

    // table at frame address F holds entry i at word ((F >> 3) + i) mod depth
    function automatic word_addr_t word_at(input logic [PA_W-1:0] frame_addr,
                                           input logic [IDX_W-1:0] idx);
        logic [63:0] sum;
        sum = {15'b0, frame_addr[PA_W-1:3]} + {55'b0, idx};
        return sum[AW-1:0];
    endfunction

    function automatic word_addr_t store_word(input logic [SIDX_W-1:0] sidx);
        logic [63:0] wide;
        wide = {52'b0, sidx};
        return wide[AW-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                      input logic [1:0] level);
        logic [IDX_W-1:0] idx;
        case (level)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ sv/ptw_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_ctrl
// Sequencer: accepts a word, steps the table walk level by level and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module ptw_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [1:0]          s_op,
    output logic                m_valid,
    input  wire                 m_ready,
    input  ptw_pkg::dp_status_t dp_status,
    output ptw_pkg::dp_cmd_t    dp_cmd
);
    import ptw_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg & ~m_ready;
        dp_cmd       = '0;
        dp_cmd.addr_sel = ADDR_SIDX;
        dp_cmd.res_sel  = RES_ZERO;

        case (state_reg)
            S_IDLE: begin
                // no word is taken while reset is held
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    dp_cmd.load_in = 1'b1;
                    case (op_t'(s_op))
                        OP_WRITE: state_next = S_WRITE;
                        OP_READ:  state_next = S_READ;
                        default:  state_next = S_WALK;
                    endcase
                end
            end
            S_WRITE: begin
                dp_cmd.mem_wr   = 1'b1;
                dp_cmd.addr_sel = ADDR_SIDX;
                dp_cmd.res_load = 1'b1;
                dp_cmd.res_sel  = RES_ZERO;
                state_next      = S_FINISH;
            end
            S_READ: begin
                dp_cmd.mem_rd   = 1'b1;
                dp_cmd.addr_sel = ADDR_SIDX;
                state_next      = S_RDWAIT;
            end
            S_RDWAIT: begin
                dp_cmd.res_load = 1'b1;
                dp_cmd.res_sel  = RES_READ;
                state_next      = S_FINISH;
            end
            S_WALK: begin
                dp_cmd.mem_rd    = 1'b1;
                dp_cmd.addr_sel  = ADDR_ROOT;
                dp_cmd.level_clr = 1'b1;
                state_next       = S_CHECK;
            end
            S_CHECK: begin
                if (!dp_status.present) begin
                    dp_cmd.res_load = 1'b1;
                    dp_cmd.res_sel  = RES_FAULT;
                    state_next      = S_FINISH;
                end else if (dp_status.op == OP_TRANSLATE && dp_status.huge &&
                             dp_status.level == 2'd1) begin
                    dp_cmd.res_load = 1'b1;
                    dp_cmd.res_sel  = RES_GIB;
                    state_next      = S_FINISH;
                end else if (dp_status.op == OP_TRANSLATE && dp_status.huge &&
                             dp_status.level == 2'd2) begin
                    dp_cmd.res_load = 1'b1;
                    dp_cmd.res_sel  = RES_MIB;
                    state_next      = S_FINISH;
                end else if (dp_status.level == 2'd3) begin
                    dp_cmd.res_load = 1'b1;
                    if (dp_status.op == OP_TRANSLATE) begin
                        dp_cmd.res_sel = RES_LEAF;
                        state_next     = S_FINISH;
                    end else begin
                        dp_cmd.res_sel = RES_UNMAP;
                        state_next     = S_CLEAR;
                    end
                end else begin
                    // descend: next read issued straight from the fetched entry
                    dp_cmd.mem_rd    = 1'b1;
                    dp_cmd.addr_sel  = ADDR_NEXT;
                    dp_cmd.level_inc = 1'b1;
                end
            end
            S_CLEAR: begin
                dp_cmd.mem_wr     = 1'b1;
                dp_cmd.addr_sel   = ADDR_LAST;
                dp_cmd.wdata_zero = 1'b1;
                state_next        = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    dp_cmd.out_load = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/ptw_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_datapath
// Table store, root register, walk registers, result staging and the output
// register.
// ----------------------------------------------------------------------------
module ptw_datapath (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_wr_en,
    input  wire  [51:0]         cfg_wr_data,
    input  wire  [1:0]          s_op,
    input  wire  [47:0]         s_virt_addr,
    input  wire  [11:0]         s_store_index,
    input  wire  [63:0]         s_entry_value,
    input  ptw_pkg::dp_cmd_t    dp_cmd,
    output ptw_pkg::dp_status_t dp_status,
    output logic                m_status,
    output logic [51:0]         m_phys_addr,
    output logic [63:0]         m_entry_out,
    output logic [1:0]          m_pg_size
);
    import ptw_pkg::*;

    logic [ENT_W-1:0] store_mem [STORE_DEPTH];
    logic [ENT_W-1:0] rdata_reg;

    logic [PA_W-1:0]  root_reg;
    op_t              op_reg;
    logic [VA_W-1:0]  va_reg;
    logic [SIDX_W-1:0] sidx_reg;
    logic [ENT_W-1:0] val_reg;
    logic [1:0]       level_reg, level_next;
    word_addr_t       last_reg;

    logic             res_status_reg;
    logic [PA_W-1:0]  res_pa_reg;
    logic [ENT_W-1:0] res_ent_reg;
    logic [1:0]       res_ps_reg;

    logic             out_status_reg;
    logic [PA_W-1:0]  out_pa_reg;
    logic [ENT_W-1:0] out_ent_reg;
    logic [1:0]       out_ps_reg;

    word_addr_t       mem_addr;
    logic [ENT_W-1:0] mem_wdata;
    logic [PA_W-1:0]  ent_frame;
    logic [PA_W-1:0]  root_frame;

    logic             res_status_next;
    logic [PA_W-1:0]  res_pa_next;
    logic [ENT_W-1:0] res_ent_next;
    logic [1:0]       res_ps_next;

    assign ent_frame  = {rdata_reg[51:12], 12'b0};
    assign root_frame = {root_reg[51:12], 12'b0};
    assign level_next = level_reg + 2'd1;

    always_comb begin
        case (dp_cmd.addr_sel)
            ADDR_SIDX: mem_addr = store_word(sidx_reg);
            ADDR_ROOT: mem_addr = word_at(root_frame, level_index(va_reg, 2'd0));
            ADDR_NEXT: mem_addr = word_at(ent_frame, level_index(va_reg, level_next));
            ADDR_LAST: mem_addr = last_reg;
            default:   mem_addr = last_reg;
        endcase
    end

    assign mem_wdata = dp_cmd.wdata_zero ? '0 : val_reg;

    always_ff @(posedge aclk) begin
        if (dp_cmd.mem_wr) begin
            store_mem[mem_addr] <= mem_wdata;
        end
        if (dp_cmd.mem_rd) begin
            rdata_reg <= store_mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg  <= '0;
            level_reg <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                root_reg <= cfg_wr_data;
            end
            if (dp_cmd.level_clr) begin
                level_reg <= 2'd0;
            end else if (dp_cmd.level_inc) begin
                level_reg <= level_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load_in) begin
            op_reg   <= op_t'(s_op);
            va_reg   <= s_virt_addr;
            sidx_reg <= s_store_index;
            val_reg  <= s_entry_value;
        end
        if (dp_cmd.mem_rd) begin
            last_reg <= mem_addr;
        end
    end

    assign dp_status.op      = op_reg;
    assign dp_status.present = rdata_reg[BIT_PRESENT];
    assign dp_status.huge    = rdata_reg[BIT_HUGE];
    assign dp_status.level   = level_reg;

    always_comb begin
        res_status_next = STATUS_OK;
        res_pa_next     = '0;
        res_ent_next    = '0;
        res_ps_next     = PS_4K;
        case (dp_cmd.res_sel)
            RES_ZERO: begin
            end
            RES_FAULT: res_status_next = STATUS_FAULT;
            RES_READ:  res_ent_next    = rdata_reg;
            RES_GIB: begin
                res_pa_next  = ent_frame + {22'b0, va_reg[29:0]};
                res_ent_next = rdata_reg;
                res_ps_next  = PS_1G;
            end
            RES_MIB: begin
                res_pa_next  = ent_frame + {31'b0, va_reg[20:0]};
                res_ent_next = rdata_reg;
                res_ps_next  = PS_2M;
            end
            RES_LEAF: begin
                res_pa_next  = {rdata_reg[51:12], va_reg[11:0]};
                res_ent_next = rdata_reg;
            end
            RES_UNMAP: res_pa_next = ent_frame;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.res_load) begin
            res_status_reg <= res_status_next;
            res_pa_reg     <= res_pa_next;
            res_ent_reg    <= res_ent_next;
            res_ps_reg     <= res_ps_next;
        end
        if (dp_cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_pa_reg     <= res_pa_reg;
            out_ent_reg    <= res_ent_reg;
            out_ps_reg     <= res_ps_reg;
        end
    end

    assign m_status    = out_status_reg;
    assign m_phys_addr = out_pa_reg;
    assign m_entry_out = out_ent_reg;
    assign m_pg_size   = out_ps_reg;

endmodule

`default_nettype wire

@@ sv/four_level_page_table_walker_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top
// Four-level page table walker over a local 64-bit table store.
//
// Input channel s_*: one word per operation (write entry, read entry,
// translate, unmap). Result channel m_*: exactly one word per operation.
// cfg_wr_en/cfg_wr_data load the root table base; write it only when idle.
// One operation is in flight at a time; a new word is taken as soon as the
// sequencer is back in idle, even while the previous result waits in the
// output register. Each operation steps through the sequencer states, paced
// by the single-port store with registered read data (one read per level):
// write stores the entry, read waits for the read data, translate stops at
// a huge entry or the leaf, unmap clears the leaf; a fault ends the walk.
// Reset clears the sequencer, the output valid and the root base; the
// table store is not cleared and holds garbage until written.
// When m_ready is low the result holds in the output register; a finished
// walk then waits in its last step until the register frees.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [51:0] cfg_wr_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_op,
    input  wire  [47:0] s_virt_addr,
    input  wire  [11:0] s_store_index,
    input  wire  [63:0] s_entry_value,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_status,
    output logic [51:0] m_phys_addr,
    output logic [63:0] m_entry_out,
    output logic [1:0]  m_pg_size
);
    import ptw_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    ptw_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    ptw_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_op          (s_op),
        .s_virt_addr   (s_virt_addr),
        .s_store_index (s_store_index),
        .s_entry_value (s_entry_value),
        .dp_cmd        (dp_cmd),
        .dp_status     (dp_status),
        .m_status      (m_status),
        .m_phys_addr   (m_phys_addr),
        .m_entry_out   (m_entry_out),
        .m_pg_size     (m_pg_size)
    );

endmodule

`default_nettype wire
